// File: sv/oir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oir_pkg: types and constants for the outline interior removal block
// Field widths, register codes and reset values used by the top level.
// ----------------------------------------------------------------------------
package oir_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;

   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int COLOR_W      = 8;
   localparam int PIXEL_W      = 3 * COLOR_W;
   localparam int ROW_W        = 14;

   localparam logic [CFG_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 13'd1024;

   // register index, taken from paddr[2]
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // input item kinds
   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   localparam logic [PIXEL_W-1:0] PIXEL_BLACK = 24'h000000;
   localparam logic [PIXEL_W-1:0] PIXEL_WHITE = 24'hFFFFFF;

   localparam logic [8:0] WINDOW_ALL_BLACK = 9'h1FF;

   typedef logic [PIXEL_W-1:0] pixel_type;

endpackage
`default_nettype wire

// File: sv/oir_divmod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oir_divmod: restoring divider, one quotient bit per cycle
// Splits a pixel count into row and column for a given image width.
// ----------------------------------------------------------------------------
module oir_divmod #(
   parameter int NUM_W = 23,
   parameter int DEN_W = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numerator,
   input  wire logic [DEN_W-1:0] denominator,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient,
   output logic [DEN_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, denominator};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = numerator;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in  = fits ? DEN_W'(trial - {1'b0, denominator}) : DEN_W'(trial);
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         step_in = step_ff + CNT_W'(1);
         if (step_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// File: sv/outline_interior_removal_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// outline_interior_removal_top: 3x3 black interior removal on a pixel stream
// Keeps the two rows above the incoming pixel in one line memory and a 3x3
// window of black flags; each pixel leaves one line and one column late.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, back to back, unless req_stall holds the input
//   (counters settling, or a full output register); a result passes the line
//   memory read, then the window stage into the output register.
// After a register write the block re-derives its counters through the
//   bit-serial divider before it takes the next item.
// Reset: synchronous; clears counters, window, hold and handshake state. The
//   line memory is not cleared; first-row entries are read before written.
// ----------------------------------------------------------------------------
module outline_interior_removal_top #(
   parameter int MAX_WIDTH = oir_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input items
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_action,
   input  wire logic [oir_pkg::COLOR_W-1:0]       req_in_red,
   input  wire logic [oir_pkg::COLOR_W-1:0]       req_in_green,
   input  wire logic [oir_pkg::COLOR_W-1:0]       req_in_blue,
   // result items
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [oir_pkg::COLOR_W-1:0]            rsp_out_red,
   output logic [oir_pkg::COLOR_W-1:0]            rsp_out_green,
   output logic [oir_pkg::COLOR_W-1:0]            rsp_out_blue,
   output logic                                   rsp_is_last,
   // register port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [oir_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [oir_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [oir_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   localparam int AW = $clog2(MAX_WIDTH);          // column / memory address
   localparam int WW = $clog2(MAX_WIDTH + 1);      // effective width
   localparam int HW = oir_pkg::CFG_HEIGHT_W;      // height, output row
   localparam int CW = WW + HW;                    // pixel count, image size
   localparam int RW = oir_pkg::ROW_W;             // input row
   localparam int PW = RW + WW;                    // stream position
   localparam int PX = oir_pkg::PIXEL_W;
   localparam int MW = 2 * PX;                     // {upper, middle} entry

   // settle sequencer codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TOTAL = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_POS   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------
   logic [oir_pkg::CFG_WIDTH_W-1:0]  iwidth_ff;
   logic [oir_pkg::CFG_HEIGHT_W-1:0] iheight_ff;
   logic                             cfg_wr;
   logic                             cfg_index;

   assign csr_pready = 1'b1;
   assign cfg_index  = csr_paddr[2];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         iwidth_ff  <= oir_pkg::IMAGE_WIDTH_RESET;
         iheight_ff <= oir_pkg::IMAGE_HEIGHT_RESET;
      end else if (cfg_wr) begin
         case (cfg_index)
            oir_pkg::REG_IMAGE_WIDTH: begin
               iwidth_ff <= csr_pwdata[oir_pkg::CFG_WIDTH_W-1:0];
            end
            oir_pkg::REG_IMAGE_HEIGHT: begin
               iheight_ff <= csr_pwdata[oir_pkg::CFG_HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (cfg_index)
         oir_pkg::REG_IMAGE_WIDTH:  csr_prdata = oir_pkg::CSR_DATA_W'(iwidth_ff);
         oir_pkg::REG_IMAGE_HEIGHT: csr_prdata = oir_pkg::CSR_DATA_W'(iheight_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // Clamp width to 1..MAX_WIDTH and height to at least one row.
   logic [WW-1:0] weff;
   logic [HW-1:0] heff;

   always_comb begin
      if (iwidth_ff == '0) begin
         weff = WW'(1);
      end else if (32'(iwidth_ff) > MAX_WIDTH) begin
         weff = WW'(MAX_WIDTH);
      end else begin
         weff = WW'(iwidth_ff);
      end
      heff = (iheight_ff == '0) ? HW'(1) : iheight_ff;
   end

   // ------------------------------------------------------------------------
   // Stream counters (stage 0)
   // ------------------------------------------------------------------------
   logic [AW-1:0] col_ff, col_in;      // input column
   logic [RW-1:0] row_ff, row_in;      // input row
   logic [PW-1:0] pos_ff, pos_in;      // row * width + column
   logic [CW-1:0] cnt_ff, cnt_in;      // results given in this image
   logic [HW-1:0] orow_ff, orow_in;    // cnt / width
   logic [AW-1:0] ocol_ff, ocol_in;    // cnt % width
   logic [CW-1:0] total_ff;            // width * height, as settled
   logic          dirty_ff;            // registers changed, counters stale

   logic          req_accept;
   logic          s1_go;
   logic          drain0, emit0, last0, intpos0;
   logic          col_wrap, ocol_wrap;
   logic [PX-1:0] pix0;

   // settle results
   logic [2:0]    st_ff, st_in;
   logic [CW-1:0] tot_new_ff;
   logic          rst_new_ff;
   logic [AW-1:0] col_new_ff;
   logic [RW-1:0] row_new_ff;
   logic [PW-1:0] pos_new_ff;
   logic          commit;
   logic          div_start, div_done;
   logic [CW-1:0] div_quo;
   logic [WW-1:0] div_rem;

   assign req_accept = req_valid && !req_stall;

   // A pixel past the image end counts as a drain step.
   assign drain0    = (req_action == oir_pkg::ACTION_DRAIN) || (pos_ff >= PW'(total_ff));
   assign pix0      = drain0 ? oir_pkg::PIXEL_BLACK
                             : {req_in_red, req_in_green, req_in_blue};
   // a result is due once a full line plus one pixel is buffered
   assign emit0     = pos_ff > PW'(weff);
   assign last0     = (cnt_ff + CW'(1)) == total_ff;
   assign col_wrap  = (WW'(col_ff) + WW'(1)) == weff;
   assign ocol_wrap = (WW'(ocol_ff) + WW'(1)) == weff;
   // interior means off the image border on all four sides
   assign intpos0   = (orow_ff != '0) &&
                      ((HW + 1)'(orow_ff) + (HW + 1)'(2) <= (HW + 1)'(heff)) &&
                      (ocol_ff != '0) &&
                      ((WW + 1)'(ocol_ff) + (WW + 1)'(2) <= (WW + 1)'(weff));

   assign commit = (st_ff == ST_DIV) && div_done && !cfg_wr;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      if (commit) begin
         if (rst_new_ff) begin
            col_in  = '0;
            row_in  = '0;
            pos_in  = '0;
            cnt_in  = '0;
            orow_in = '0;
            ocol_in = '0;
         end else begin
            col_in  = col_new_ff;
            row_in  = row_new_ff;
            pos_in  = pos_new_ff;
            orow_in = HW'(div_quo);
            ocol_in = AW'(div_rem);
         end
      end else if (req_accept) begin
         if (emit0 && last0) begin
            // final result of the image: start the next image clean
            col_in  = '0;
            row_in  = '0;
            pos_in  = '0;
            cnt_in  = '0;
            orow_in = '0;
            ocol_in = '0;
         end else begin
            pos_in = pos_ff + PW'(1);
            if (col_wrap) begin
               col_in = '0;
               row_in = row_ff + RW'(1);
            end else begin
               col_in = col_ff + AW'(1);
            end
            if (emit0) begin
               cnt_in = cnt_ff + CW'(1);
               if (ocol_wrap) begin
                  ocol_in = '0;
                  orow_in = orow_ff + HW'(1);
               end else begin
                  ocol_in = ocol_ff + AW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         orow_ff  <= '0;
         ocol_ff  <= '0;
         total_ff <= CW'(32'(oir_pkg::IMAGE_WIDTH_RESET) * 32'(oir_pkg::IMAGE_HEIGHT_RESET));
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pos_ff  <= pos_in;
         cnt_ff  <= cnt_in;
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
         if (commit) begin
            total_ff <= tot_new_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Settle sequencer: after a register write, re-derive image size, restart,
   // column wrap, stream position and output row/column for the new shape.
   // Everything is staged and committed at once; a new write aborts.
   // Start only when an item is waiting so back-to-back writes see the last
   // values.
   // ------------------------------------------------------------------------
   always_comb begin
      st_in     = st_ff;
      div_start = 1'b0;
      if (cfg_wr) begin
         st_in = ST_IDLE;
      end else begin
         case (st_ff)
            ST_IDLE: begin
               if (dirty_ff && req_valid) begin
                  st_in = ST_TOTAL;
               end
            end
            ST_TOTAL: st_in = ST_CHECK;
            ST_CHECK: st_in = ST_POS;
            ST_POS: begin
               div_start = 1'b1;
               st_in     = ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  st_in = ST_IDLE;
               end
            end
            default: st_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         dirty_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (cfg_wr) begin
            dirty_ff <= 1'b1;
         end else if (commit) begin
            dirty_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_TOTAL: begin
            tot_new_ff <= CW'(weff) * CW'(heff);
         end
         ST_CHECK: begin
            rst_new_ff <= cnt_ff >= tot_new_ff;
            if (WW'(col_ff) >= weff) begin
               col_new_ff <= '0;
               row_new_ff <= row_ff + RW'(1);
            end else begin
               col_new_ff <= col_ff;
               row_new_ff <= row_ff;
            end
         end
         ST_POS: begin
            pos_new_ff <= PW'(row_new_ff) * PW'(weff) + PW'(col_new_ff);
         end
         default: begin
         end
      endcase
   end

   oir_divmod #(
      .NUM_W (CW),
      .DEN_W (WW)
   ) u_divmod (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (cnt_ff),
      .denominator (weff),
      .done        (div_done),
      .quotient    (div_quo),
      .remainder   (div_rem)
   );

   // ------------------------------------------------------------------------
   // Line memory: entry per column holds {row above-above, row above}.
   // Read at accept, read-modify-write one stage later.
   // ------------------------------------------------------------------------
   logic [MW-1:0] line_mem [MAX_WIDTH];
   logic [MW-1:0] mem_rd_ff;
   logic [MW-1:0] wdata;
   logic [MW-1:0] fwd_data_ff;
   logic          fwd_ff;

   // stage 1 holding registers
   logic          s1_valid_ff;
   logic [AW-1:0] s1_col_ff;
   logic [PX-1:0] s1_pix_ff;
   logic          s1_drain_ff;
   logic          s1_emit_ff;
   logic          s1_last_ff;
   logic          s1_intpos_ff;
   logic          s1_restart_ff;

   always_ff @(posedge clock) begin
      if (s1_go) begin
         line_mem[s1_col_ff] <= wdata;
      end
      if (req_accept) begin
         mem_rd_ff <= line_mem[col_ff];
      end
   end

   // Same column written and read on one edge (for example at a width of one): forward.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         fwd_ff      <= s1_go && (s1_col_ff == col_ff);
         fwd_data_ff <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff     <= col_ff;
         s1_pix_ff     <= pix0;
         s1_drain_ff   <= drain0;
         s1_emit_ff    <= emit0;
         s1_last_ff    <= last0;
         s1_intpos_ff  <= intpos0;
         s1_restart_ff <= emit0 && last0;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: window of black flags and the delayed center pixel
   // ------------------------------------------------------------------------
   logic [MW-1:0] eff_rd;
   logic [PX-1:0] above_pix, mid_pix;
   logic [2:0]    col_flags;
   logic [8:0]    flags_ff, flags_new;
   logic [PX-1:0] hold_ff;
   logic          out_free;
   logic          interior;

   logic          rsp_valid_ff;
   logic [PX-1:0] rsp_pix_ff;
   logic          rsp_last_ff;

   assign eff_rd    = fwd_ff ? fwd_data_ff : mem_rd_ff;
   assign above_pix = eff_rd[MW-1:PX];
   assign mid_pix   = eff_rd[PX-1:0];
   assign wdata     = {mid_pix, s1_pix_ff};
   assign col_flags = {(!s1_drain_ff && (s1_pix_ff == oir_pkg::PIXEL_BLACK)),
                       (mid_pix == oir_pkg::PIXEL_BLACK),
                       (above_pix == oir_pkg::PIXEL_BLACK)};
   assign flags_new = {flags_ff[5:0], col_flags};
   assign interior  = s1_intpos_ff && (flags_new == oir_pkg::WINDOW_ALL_BLACK);

   // An item with no result needs no room in the output register.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (out_free || !s1_emit_ff);
   assign req_stall = dirty_ff || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         hold_ff  <= oir_pkg::PIXEL_BLACK;
      end else if (commit && rst_new_ff) begin
         flags_ff <= '0;
         hold_ff  <= oir_pkg::PIXEL_BLACK;
      end else if (s1_go) begin
         if (s1_restart_ff) begin
            // drop the window and hold at the image end
            flags_ff <= '0;
            hold_ff  <= oir_pkg::PIXEL_BLACK;
         end else begin
            flags_ff <= flags_new;
            hold_ff  <= mid_pix;
         end
      end
   end

   // Output register: advance on a new result, drop when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_pix_ff  <= interior ? oir_pkg::PIXEL_WHITE : hold_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_pix_ff[PX-1:PX-oir_pkg::COLOR_W];
   assign rsp_out_green = rsp_pix_ff[PX-oir_pkg::COLOR_W-1:oir_pkg::COLOR_W];
   assign rsp_out_blue  = rsp_pix_ff[oir_pkg::COLOR_W-1:0];
   assign rsp_is_last   = rsp_last_ff;

endmodule
`default_nettype wire

// File: sv/oir_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oir_checker: port-level checks for the outline interior removal block
// Watches the handshakes and the register port over time.
// ----------------------------------------------------------------------------
module oir_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic csr_pready
);

   // result item held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // no result item right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item visible after reset");

   // a new result must trace back to an accepted input item
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result item without a cause");

   // a register write holds off input items while counters re-settle
   a_cfg_stall: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready |=> req_stall)
      else $error("input item taken right after a register write");

endmodule

bind outline_interior_removal_top oir_checker u_oir_checker (.*);
`default_nettype wire
